[rtl/msgf_pkg.sv]
// Shared widths and result flag layout for the missing sample gap filler.
`timescale 1ns / 1ps

package msgf_pkg;

  // Pending gap counter width and the run counter that also holds gap + 1
  localparam int GAP_W = 6;
  localparam int CNT_W = GAP_W + 1;

  // Result flags as carried on the master tuser bus, highest bit first
  typedef struct packed {
    logic run_last;
    logic overflow;
    logic still_missing;
  } out_user_t;

endpackage

[rtl/missing_sample_gap_filler.sv]
// Gap filler: holds, copies or linearly interpolates missing samples of a series.
//
//  channel  dir  tdata                tuser                                    tlast
//  s_*      in   sample               [0] missing                              series_last
//  m_*      out  value                [0] still_missing [1] overflow [2] run_last  series_end
//
// A valid sample with no pending gap goes straight to the output register.
// A held or copied run sends its results in turn. An interpolated gap of g
// samples runs a shift-subtract divider (one quotient bit a cycle), a slope
// sign fix, then g results from the step adder and the closing sample.
// Synchronous active-high reset clears the sequencer, the series state and
// the output valid. A stalled master side holds runs and input; division goes on.
`timescale 1ns / 1ps

module missing_sample_gap_filler
  import msgf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_GAP      = 63
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample
  input  logic [0:0]                            s_tuser,   // missing
  input  logic                                  s_tlast,   // series_last
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,   // value
  output logic [2:0]                            m_tuser,   // still_missing, overflow, run_last
  output logic                                  m_tlast    // series_end
);

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int QW     = SAMPLE_WIDTH + 2;
  localparam int DCW    = $clog2(SAMPLE_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  // Sequencer and series state
  logic [1:0]                     state;
  logic signed [SAMPLE_WIDTH-1:0] last_good;
  logic                           have_good;
  logic [GAP_W-1:0]               gap_count;

  // Run control
  logic signed [SAMPLE_WIDTH-1:0] tail_val;
  logic                           tail_last;
  logic                           tail;
  logic                           interp;
  logic [CNT_W-1:0]               run_cnt;
  logic signed [SAMPLE_WIDTH-1:0] fill_val;
  logic                           fill_sm;
  logic                           fill_ov;

  // Divider
  logic [SAMPLE_WIDTH-1:0]        dvd_q;
  logic [CNT_W-1:0]               rem;
  logic [CNT_W-1:0]               divisor;
  logic                           div_neg;
  logic [DCW-1:0]                 div_cnt;

  // Interpolation stepper: numerator = q * divisor + r, 0 <= r < divisor
  logic signed [QW-1:0]           q;
  logic signed [QW-1:0]           qd;
  logic [CNT_W-1:0]               r;
  logic [CNT_W-1:0]               rd;

  // Output register
  logic signed [SAMPLE_WIDTH-1:0] out_value;
  out_user_t                      out_user;
  logic                           out_last;

  logic                           acc;
  logic                           out_free;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic                           in_miss;
  logic                           in_last;
  logic signed [SAMPLE_WIDTH:0]   delta;
  logic [SAMPLE_WIDTH:0]          delta_abs;
  logic                           gap_full;
  logic signed [SAMPLE_WIDTH-1:0] hold_val;
  logic [CNT_W-1:0]               rem_sh;
  logic                           rem_ge;
  logic [CNT_W-1:0]               rem_new;
  logic                           rem_nz;
  logic signed [QW-1:0]           quot_ext;
  logic signed [QW-1:0]           q_sum;
  logic [CNT_W-1:0]               r_sum;
  logic                           r_wrap;
  logic signed [QW-1:0]           nq;
  logic [CNT_W-1:0]               nr;
  logic signed [QW-1:0]           step_q;
  logic signed [SAMPLE_WIDTH-1:0] step_val;
  logic [CNT_W-1:0]               gap_ext;

  // Handshake and input decode
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign acc       = s_tvalid && s_tready;
  assign in_sample = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
  assign in_miss   = s_tuser[0];
  assign in_last   = s_tlast;

  assign gap_ext   = {1'b0, gap_count};
  assign gap_full  = gap_count >= GAP_W'(MAX_GAP);
  assign hold_val  = have_good ? last_good : '0;

  // Slope numerator across the gap and its magnitude for the divider
  assign delta     = (SAMPLE_WIDTH+1)'(in_sample) - (SAMPLE_WIDTH+1)'(last_good);
  assign delta_abs = delta[SAMPLE_WIDTH] ? -delta : delta;

  // Shift-subtract divider step
  assign rem_sh  = {rem[CNT_W-2:0], dvd_q[SAMPLE_WIDTH-1]};
  assign rem_ge  = rem_sh >= divisor;
  assign rem_new = rem_ge ? rem_sh - divisor : rem_sh;

  // Floor quotient and remainder of the slope
  assign rem_nz   = rem != '0;
  assign quot_ext = $signed({2'b00, dvd_q});

  // Stepper: add slope, fold remainder once, round toward zero on output
  assign q_sum    = q + qd;
  assign r_sum    = r + rd;
  assign r_wrap   = r_sum >= divisor;
  assign nr       = r_wrap ? r_sum - divisor : r_sum;
  assign nq       = q_sum + QW'(r_wrap);
  assign step_q   = nq + QW'(nq[QW-1] && (nr != '0));
  assign step_val = step_q[SAMPLE_WIDTH-1:0];

  // Ports
  assign m_tdata = DATA_W'($unsigned(out_value));
  assign m_tuser = out_user;
  assign m_tlast = out_last;

  // Sequencer, series state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_good <= '0;
      have_good <= 1'b0;
      gap_count <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            tail_val  <= in_sample;
            tail_last <= in_last;
            if (!in_miss) begin
              last_good <= in_sample;
              have_good <= 1'b1;
              gap_count <= '0;
              if (gap_count == '0) begin
                out_value <= in_sample;
                out_user  <= '{run_last: 1'b1, overflow: 1'b0, still_missing: 1'b0};
                out_last  <= in_last;
                m_tvalid  <= 1'b1;
              end else if (!have_good) begin
                // leading gap copies the first valid sample
                fill_val <= in_sample;
                fill_sm  <= 1'b0;
                fill_ov  <= 1'b0;
                run_cnt  <= gap_ext;
                tail     <= 1'b1;
                interp   <= 1'b0;
                state    <= ST_RUN;
              end else begin
                // inner gap: divide the slope by gap + 1 first
                divisor <= gap_ext + CNT_W'(1);
                dvd_q   <= delta_abs[SAMPLE_WIDTH-1:0];
                div_neg <= delta[SAMPLE_WIDTH];
                rem     <= '0;
                div_cnt <= DCW'(SAMPLE_WIDTH - 1);
                q       <= QW'(last_good);
                r       <= '0;
                run_cnt <= gap_ext;
                tail    <= 1'b1;
                interp  <= 1'b1;
                state   <= ST_DIV;
              end
            end else if (in_last || gap_full) begin
              // trailing or overflowing gap flushes held copies
              fill_val  <= hold_val;
              fill_sm   <= !have_good;
              fill_ov   <= !in_last;
              run_cnt   <= gap_ext + CNT_W'(1);
              tail      <= 1'b0;
              interp    <= 1'b0;
              gap_count <= '0;
              state     <= ST_RUN;
            end else begin
              gap_count <= gap_count + GAP_W'(1);
            end
            // series end returns the series state to its reset value
            if (in_last) begin
              last_good <= '0;
              have_good <= 1'b0;
              gap_count <= '0;
            end
          end
        end
        ST_DIV: begin
          dvd_q <= {dvd_q[SAMPLE_WIDTH-2:0], rem_ge};
          rem   <= rem_new;
          if (div_cnt == '0) begin
            state <= ST_FIX;
          end else begin
            div_cnt <= div_cnt - DCW'(1);
          end
        end
        ST_FIX: begin
          qd    <= div_neg ? -quot_ext - QW'(rem_nz) : quot_ext;
          rd    <= (div_neg && rem_nz) ? divisor - rem : rem;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (run_cnt != '0) begin
              out_value <= interp ? step_val : fill_val;
              out_user  <= '{run_last: (run_cnt == CNT_W'(1)) && !tail,
                             overflow: !interp && fill_ov,
                             still_missing: !interp && fill_sm};
              out_last  <= (run_cnt == CNT_W'(1)) && !tail && tail_last;
              run_cnt   <= run_cnt - CNT_W'(1);
              if (interp) begin
                q <= nq;
                r <= nr;
              end
              if ((run_cnt == CNT_W'(1)) && !tail) begin
                state <= ST_IDLE;
              end
            end else begin
              // the valid sample that closed the gap
              out_value <= tail_val;
              out_user  <= '{run_last: 1'b1, overflow: 1'b0, still_missing: 1'b0};
              out_last  <= tail_last;
              state     <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Pending gap never grows past the limit
  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    gap_count <= GAP_W'(MAX_GAP))
    else $error("gap count above limit");

  // A plain missing sample only counts, it starts no run
  a_miss_quiet: assert property (@(posedge clk) disable iff (rst)
    acc && in_miss && !in_last && !gap_full |=> state == ST_IDLE)
    else $error("missing sample left idle");

  // An empty fill count in a run means the closing sample is still due
  a_run_tail: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && run_cnt == '0 |-> tail)
    else $error("run with nothing left to send");

  // Series end clears the series state
  a_series_clear: assert property (@(posedge clk) disable iff (rst)
    acc && in_last |=> !have_good && gap_count == '0)
    else $error("series state not cleared at series end");
`endif

endmodule
